>>> src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> src/i2a_pkg.sv
// Shared types, codes and sizing functions for the integer to ASCII converter.
`default_nettype none

package i2a_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;

   typedef logic [1:0] op_type;

   localparam op_type OP_DEC   = 2'd0;
   localparam op_type OP_LOWER = 2'd1;
   localparam op_type OP_UPPER = 2'd2;
   localparam op_type OP_PTR   = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_X     = 8'd120;
   localparam logic [7:0] OFF_UPPER  = 8'd55;
   localparam logic [7:0] OFF_LOWER  = 8'd87;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   no_digits;
   } emit_cmd_type;

   function automatic int dec_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

   function automatic int hex_digits(input int w);
      return (w + 3) >> 2;
   endfunction

   function automatic int max_digits(input int w);
      return (dec_digits(w) > hex_digits(w)) ? dec_digits(w) : hex_digits(w);
   endfunction

endpackage

`default_nettype wire

>>> src/integer_to_ascii_dec_hex.sv
// Integer to ASCII converter top level: decimal magnitude or hex, one character per transaction.
// Flow: a decimal number goes through BCD conversion before its digits load into the emitter;
//   a hex number loads directly. Suppressed leading zero digits are skipped without a character.
// Requests: one number at a time; the next is taken only once its last character has left the
//   emitter, so response stalls also hold off new requests. Pointer output has a 0x prefix.
// Reset: synchronous, active high; returns to idle with no pending character.
`default_nettype none

module integer_to_ascii_dec_hex import i2a_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_op,
   input  wire logic [63:0]  req_value,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_char_out,
   output logic              rsp_last
);

   localparam int DIGITS  = max_digits(VALUE_WIDTH);
   localparam int HEXD    = hex_digits(VALUE_WIDTH);
   localparam int DBITS   = DIGITS * 4;
   localparam int HBITS   = HEXD * 4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val;
   logic [VALUE_WIDTH-1:0] mag;
   logic [HBITS-1:0]       hex_vec;
   logic [DBITS-1:0]       bcd;
   logic [DBITS-1:0]       load_dig;
   logic                   accept;
   logic                   conv_start;
   logic                   conv_done;
   logic                   emit_busy;
   emit_cmd_type           cmd;

   assign val     = req_value[VALUE_WIDTH-1:0];
   assign mag     = val[VALUE_WIDTH-1] ? (~val + VALUE_WIDTH'(1)) : val;
   assign hex_vec = HBITS'(val);
   assign accept  = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      conv_start = 1'b0;
      cmd        = '0;
      load_dig   = DBITS'(hex_vec) << (DBITS - HBITS);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_op;
               if (req_op == OP_DEC) begin
                  conv_start = 1'b1;
                  state_in   = ST_CONV;
               end else begin
                  cmd.load      = 1'b1;
                  cmd.op        = req_op;
                  cmd.no_digits = (req_op == OP_PTR) && (val == '0);
                  state_in      = ST_EMIT;
               end
            end
         end
         ST_CONV: begin
            load_dig = bcd;
            if (conv_done) begin
               cmd.load = 1'b1;
               cmd.op   = op_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   i2a_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .mag   (mag),
      .bcd   (bcd),
      .done  (conv_done)
   );

   i2a_emit #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .digits       (load_dig),
      .busy         (emit_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

>>> src/i2a_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`default_nettype none

module i2a_dabble import i2a_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int DIGITS      = max_digits(VALUE_WIDTH)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [VALUE_WIDTH-1:0]  mag,
   output logic      [DIGITS*4-1:0]     bcd,
   output logic                         done
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [DIGITS*4-1:0]    bcd_ff, bcd_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   always_comb begin
      logic [DIGITS*4-1:0] adj;
      logic [3:0]          nib;
      adj     = bcd_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
         nib = bcd_ff[i*4 +: 4];
         adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      if (start) begin
         mag_in  = mag;
         bcd_in  = '0;
         cnt_in  = CW'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[DIGITS*4-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = mag_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> src/i2a_emit.sv
// Digit shift register and character emitter with registered result output.
`default_nettype none

module i2a_emit import i2a_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int DIGITS      = max_digits(VALUE_WIDTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire emit_cmd_type          cmd,
   input  wire logic [DIGITS*4-1:0]   digits,
   output logic                       busy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_char_out,
   output logic                       rsp_last
);

   localparam int HEXD = hex_digits(VALUE_WIDTH);
   localparam int LW   = $clog2(DIGITS + 1);

   logic [DIGITS*4-1:0] dig_ff, dig_in;
   logic [LW-1:0]       left_ff, left_in;
   logic [1:0]          pre_ff, pre_in;
   logic                started_ff, started_in;
   op_type              op_ff, op_in;
   logic                valid_ff, valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic [3:0]          top;
   logic [7:0]          off;
   logic                out_free;

   assign top      = dig_ff[DIGITS*4-1 -: 4];
   assign off      = (top <= 4'd9) ? CHAR_ZERO : ((op_ff == OP_UPPER) ? OFF_UPPER : OFF_LOWER);
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      dig_in     = dig_ff;
      left_in    = left_ff;
      pre_in     = pre_ff;
      started_in = started_ff;
      op_in      = op_ff;
      valid_in   = valid_ff && !rsp_ready;
      char_in    = char_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         dig_in     = digits;
         op_in      = cmd.op;
         started_in = 1'b0;
         pre_in     = (cmd.op == OP_PTR) ? 2'd2 : 2'd0;
         if (cmd.no_digits) begin
            left_in = '0;
         end else if (cmd.op == OP_DEC) begin
            left_in = LW'(DIGITS);
         end else begin
            left_in = LW'(HEXD);
         end
      end else if (out_free) begin
         if (pre_ff != 2'd0) begin
            valid_in = 1'b1;
            char_in  = (pre_ff == 2'd2) ? CHAR_ZERO : CHAR_X;
            last_in  = (pre_ff == 2'd1) && (left_ff == '0);
            pre_in   = pre_ff - 2'd1;
         end else if (left_ff != '0) begin
            dig_in  = dig_ff << 4;
            left_in = left_ff - LW'(1);
            if (started_ff || (top != 4'd0) || (left_ff == LW'(1))) begin
               valid_in   = 1'b1;
               char_in    = {4'd0, top} + off;
               last_in    = (left_ff == LW'(1));
               started_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      op_ff   <= op_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         left_ff    <= '0;
         pre_ff     <= 2'd0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         left_ff    <= left_in;
         pre_ff     <= pre_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   assign busy         = valid_ff || (pre_ff != 2'd0) || (left_ff != '0);
   assign rsp_valid    = valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

>>> src/i2a_checker.sv
// Port-level checker for the integer to ASCII converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module i2a_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_char_out,
   input wire logic        rsp_last
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_busy_until_last, clock, reset, rsp_valid && rsp_ready && !rsp_last, !req_ready)

endmodule

bind integer_to_ascii_dec_hex i2a_checker u_i2a_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

`default_nettype wire

>>> bench/integer_to_ascii_dec_hex_tb.sv
// Testbench for the integer to ASCII converter: queued driver, character monitor, predictor.
`timescale 1ns / 1ps

module integer_to_ascii_dec_hex_tb import i2a_pkg::*;;

   typedef struct {
      op_type      op;
      logic [63:0] value;
      logic        drain;
   } number_item_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_DEC;
   logic [63:0] req_value = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   number_item_type pending_numbers[$];
   char_item_type   expected_chars[$];
   number_item_type next_number;
   char_item_type   oldest_char;
   logic         req_taken = 1'b0;
   int           burst_left = 1;
   int           gap_left = 0;
   logic [7:0]   stall_pattern = 8'hFF;
   logic [2:0]   stall_phase = 3'd0;
   int           stall_left = 32;
   int           error_count = 0;

   integer_to_ascii_dec_hex dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void predict_chars(input op_type op, input logic [63:0] value);
      logic [63:0] mag;
      logic [63:0] base;
      logic [63:0] d;
      logic [7:0]  alpha_off;
      logic [7:0]  digits[$];
      char_item_type item;
      mag = value;
      base = 64'd16;
      alpha_off = (op == OP_UPPER) ? OFF_UPPER : OFF_LOWER;
      if (op == OP_DEC) begin
         base = 64'd10;
         if (value[63]) begin
            mag = -value;
         end
      end
      if (op == OP_PTR) begin
         digits.push_back(CHAR_ZERO);
         digits.push_back(CHAR_X);
      end
      if (op != OP_PTR || value != 64'd0) begin
         do begin
            d = mag % base;
            mag = mag / base;
            digits.insert((op == OP_PTR) ? 2 : 0,
               (d <= 9) ? CHAR_ZERO + d[7:0] : alpha_off + d[7:0]);
         end while (mag != 64'd0);
      end
      foreach (digits[i]) begin
         item.ch = digits[i];
         item.last = (i == digits.size() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   task automatic add_number(input op_type op, input logic [63:0] value, input logic drain);
      number_item_type item;
      item.op = op;
      item.value = value;
      item.drain = drain;
      pending_numbers.push_back(item);
   endtask

   // drive requests in bursts; hold payload until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (gap_left != 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_numbers.size() == 0 ||
                   (pending_numbers[0].drain && expected_chars.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         next_number = pending_numbers.pop_front();
         req_op <= next_number.op;
         req_value <= next_number.value;
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // stall the response channel on a rotating pattern
   always @(negedge clock) begin
      rsp_ready <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 3'd1;
      if (stall_left <= 1) begin
         stall_left <= $urandom_range(16, 200);
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom | 32'd1);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // check characters, then predict for a newly accepted number
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                  rsp_char_out, rsp_last));
            end else begin
               oldest_char = expected_chars.pop_front();
               if (rsp_char_out !== oldest_char.ch) begin
                  report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
                     rsp_char_out, oldest_char.ch));
               end
               if (rsp_last !== oldest_char.last) begin
                  report_mismatch($sformatf("last %0b, want %0b", rsp_last, oldest_char.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_chars(op_type'(req_op), req_value);
         end
         req_taken <= req_valid && req_ready;
      end
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int          k;
      int          shape;
      logic [63:0] v;
      logic [63:0] p;
      op_type      op;

      for (k = 0; k < 4; k++) begin
         op = op_type'(k);
         add_number(op, 64'd0, 1'b0);
         add_number(op, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
         add_number(op, 64'h8000_0000_0000_0000, 1'b0);
         add_number(op, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      end
      add_number(OP_LOWER, 64'h0123_4567_89AB_CDEF, 1'b1);
      add_number(OP_UPPER, 64'h0123_4567_89AB_CDEF, 1'b0);
      add_number(OP_PTR, 64'h0123_4567_89AB_CDEF, 1'b0);
      add_number(OP_LOWER, 64'hFEDC_BA98_7654_3210, 1'b0);
      add_number(OP_UPPER, 64'hFEDC_BA98_7654_3210, 1'b0);
      add_number(OP_DEC, 64'd10, 1'b0);
      add_number(OP_DEC, 64'd1, 1'b1);
      add_number(OP_DEC, 64'd999999999999999999, 1'b0);
      add_number(OP_PTR, 64'd1, 1'b0);

      for (k = 0; k < 95; k++) begin
         op = op_type'($urandom_range(0, 3));
         shape = $urandom_range(0, 5);
         case (shape)
            0, 1: v = {$urandom, $urandom};
            2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: v = $urandom_range(0, 20);
            4: begin
               p = 64'd1;
               repeat ($urandom_range(0, 19)) p = p * 64'd10;
               v = p + $urandom_range(0, 2) - 64'd1;
            end
            default: v = -({$urandom, $urandom} >> $urandom_range(0, 63));
         endcase
         add_number(op, v, $urandom_range(0, 24) == 0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_numbers.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/i2a_pkg.sv
src/i2a_dabble.sv
src/i2a_emit.sv
src/integer_to_ascii_dec_hex.sv
src/i2a_checker.sv
bench/integer_to_ascii_dec_hex_tb.sv
